// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define CHK_SAME(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("same-cycle check failed");

// next-cycle implication, off while in reset
`define CHK_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/hds_pkg.sv =====
`timescale 1ns / 1ps
package hds_pkg;

  localparam int TEMP_W         = 16;
  localparam int TEMP_FRAC_BITS = 15;
  localparam int ENTRY_W        = TEMP_W + 2;
  localparam int ACC_W          = 36;
  localparam int CW             = 20;
  localparam int CNT_W          = $clog2(ACC_W);
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 15;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_COEFF = 2'd2;

  typedef enum logic [2:0] {
    TAP_C  = 3'd0,
    TAP_UP = 3'd1,
    TAP_DN = 3'd2,
    TAP_LF = 3'd3,
    TAP_RT = 3'd4
  } tap_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_DRAIN,
    S_PREP,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_issue;
    tap_t rd_tap;
    logic div_load;
    logic div_step;
    logic out_load;
  } hds_cmd_t;

  typedef struct packed {
    logic in_free;
    logic need_out;
    logic out_busy;
  } hds_sts_t;

endpackage

// ===== rtl/hds_ram.sv =====
`timescale 1ns / 1ps
module hds_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 2050
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/hds_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hds_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hds_pkg::hds_sts_t sts,
  output hds_pkg::hds_cmd_t cmd
);
  import hds_pkg::*;

  state_t           st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_valid && sts.in_free && sts.need_out) begin
          st_nxt  = S_RD;
          cnt_nxt = '0;
        end
      end
      S_RD: begin
        if (cnt_r == CNT_W'(TAP_RT)) begin
          st_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_DRAIN: st_nxt = S_PREP;
      S_PREP: begin
        st_nxt  = S_DIV;
        cnt_nxt = '0;
      end
      S_DIV: begin
        if (cnt_r == CNT_W'(ACC_W - 1)) begin
          st_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = (st_r == S_IDLE) && sts.in_free;
    cmd          = '0;
    cmd.rd_tap   = TAP_C;
    cmd.accept   = in_ready && in_valid;
    unique case (st_r)
      S_RD: begin
        cmd.rd_issue = 1'b1;
        cmd.rd_tap   = tap_t'(cnt_r[2:0]);
      end
      S_PREP:  cmd.div_load = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_OUT:   cmd.out_load = !sts.out_busy;
      default: ;
    endcase
  end

  `CHK_NEXT(a_div_to_out, clk, rst_n, (st_r == S_DIV) && (cnt_r == CNT_W'(ACC_W - 1)), st_r == S_OUT)
  `CHK_NEXT(a_rd_to_drain, clk, rst_n, cmd.rd_issue && (cmd.rd_tap == TAP_RT), st_r == S_DRAIN)
  `CHK_SAME(a_ready_idle, clk, rst_n, in_ready, st_r == S_IDLE)

endmodule

// ===== rtl/hds_dpath.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hds_dpath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  hds_pkg::hds_cmd_t                cmd,
  output hds_pkg::hds_sts_t                sts,
  input  logic                             in_action,
  input  logic [hds_pkg::TEMP_W-1:0]       in_temperature,
  input  logic                             in_is_fixed,
  input  logic                             in_is_insulator,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hds_pkg::TEMP_W-1:0]       out_new_temperature,
  output logic                             out_last_of_frame,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hds_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import hds_pkg::*;

  localparam int DEPTH = 2 * MAX_WIDTH + 2;
  localparam int A_W   = $clog2(DEPTH);
  localparam int W_W   = $clog2(MAX_WIDTH + 1);
  localparam int H_W   = $clog2(MAX_HEIGHT + 1);
  localparam int IDX_W = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2);
  localparam logic [ACC_W-1:0] ONE = ACC_W'(1) << TEMP_FRAC_BITS;

  // configuration
  logic [10:0] gw_r, gh_r;
  logic [14:0] oc_r;
  logic        cfg_hold_r;
  logic        cfg_we, geo_we;
  logic [W_W-1:0] w_eff;
  logic [H_W-1:0] h_eff;
  logic [W_W+H_W-1:0] prod;
  logic [IDX_W-1:0]   total_r;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign geo_we    = cfg_we && ((cfg_index == REG_GRID_WIDTH) || (cfg_index == REG_GRID_HEIGHT));

  always_comb begin
    if (gw_r < 11'd3) begin
      w_eff = W_W'(3);
    end else if (32'(gw_r) > MAX_WIDTH) begin
      w_eff = W_W'(MAX_WIDTH);
    end else begin
      w_eff = W_W'(gw_r);
    end
    if (gh_r < 11'd3) begin
      h_eff = H_W'(3);
    end else if (32'(gh_r) > MAX_HEIGHT) begin
      h_eff = H_W'(MAX_HEIGHT);
    end else begin
      h_eff = H_W'(gh_r);
    end
  end

  assign prod = {{H_W{1'b0}}, w_eff} * {{W_W{1'b0}}, h_eff};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r       <= 11'd1024;
      gh_r       <= 11'd1024;
      oc_r       <= 15'd819;
      cfg_hold_r <= 1'b1;
    end else begin
      cfg_hold_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GRID_WIDTH:  gw_r <= cfg_data[10:0];
          REG_GRID_HEIGHT: gh_r <= cfg_data[10:0];
          REG_OUTER_COEFF: oc_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    total_r <= IDX_W'(prod);
  end

  // position counters and ring pointer
  logic [IDX_W-1:0] in_k_r;
  logic [W_W-1:0]   out_x_r;
  logic [H_W-1:0]   out_y_r;
  logic [A_W-1:0]   wr_ptr_r;
  logic             is_last;

  assign is_last = (out_x_r == w_eff - W_W'(1)) && (out_y_r == h_eff - H_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_k_r   <= '0;
      out_x_r  <= '0;
      out_y_r  <= '0;
      wr_ptr_r <= '0;
    end else begin
      if (cmd.accept) begin
        in_k_r   <= in_k_r + IDX_W'(1);
        wr_ptr_r <= (wr_ptr_r == A_W'(DEPTH - 1)) ? '0 : wr_ptr_r + A_W'(1);
      end
      if (geo_we) begin
        in_k_r  <= '0;
        out_x_r <= '0;
        out_y_r <= '0;
      end else if (cmd.out_load) begin
        if (is_last) begin
          in_k_r  <= '0;
          out_x_r <= '0;
          out_y_r <= '0;
        end else if (out_x_r == w_eff - W_W'(1)) begin
          out_x_r <= '0;
          out_y_r <= out_y_r + H_W'(1);
        end else begin
          out_x_r <= out_x_r + W_W'(1);
        end
      end
    end
  end

  assign sts.in_free  = !cfg_hold_r;
  assign sts.need_out = in_k_r >= ({{(IDX_W-W_W){1'b0}}, w_eff} + IDX_W'(1));
  assign sts.out_busy = out_valid && !out_ready;

  // ring store
  logic [ENTRY_W-1:0] wdata, rdata;
  logic               cell_ok;
  logic [A_W:0]       w1, back_d, asum;
  logic [A_W-1:0]     raddr;

  assign cell_ok = (in_k_r < total_r) && !in_action;
  assign wdata   = cell_ok ? {in_is_insulator, in_is_fixed, in_temperature}
                           : {1'b1, 1'b0, {TEMP_W{1'b0}}};

  assign w1 = (A_W+1)'(w_eff);

  always_comb begin
    unique case (cmd.rd_tap)
      TAP_C:   back_d = w1 + (A_W+1)'(2);
      TAP_UP:  back_d = (w1 << 1) + (A_W+1)'(2);
      TAP_DN:  back_d = (A_W+1)'(2);
      TAP_LF:  back_d = w1 + (A_W+1)'(3);
      TAP_RT:  back_d = w1 + (A_W+1)'(1);
      default: back_d = (A_W+1)'(2);
    endcase
    asum = {1'b0, wr_ptr_r} + (A_W+1)'(DEPTH) - back_d;
    if (asum >= (A_W+1)'(DEPTH)) begin
      asum = asum - (A_W+1)'(DEPTH);
    end
    raddr = asum[A_W-1:0];
  end

  hds_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (wr_ptr_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // weighted sum over the cross
  logic        dv_r;
  tap_t        tap_q_r;
  logic [16:0] ow;
  logic [15:0] iw;
  logic        nb_on;
  logic [ACC_W-1:0] acc_r;
  logic [CW-1:0]    contrib_r;
  logic [TEMP_W-1:0] tc_r;
  logic              pass_r;

  assign ow = {oc_r, 2'b00};
  assign iw = 16'd32768 - {1'b0, oc_r};

  always_comb begin
    unique case (tap_q_r)
      TAP_UP:  nb_on = out_y_r != '0;
      TAP_DN:  nb_on = out_y_r != h_eff - H_W'(1);
      TAP_LF:  nb_on = out_x_r != '0;
      TAP_RT:  nb_on = out_x_r != w_eff - W_W'(1);
      default: nb_on = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= 1'b0;
    end else begin
      dv_r <= cmd.rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    tap_q_r <= cmd.rd_tap;
    if (dv_r) begin
      if (tap_q_r == TAP_C) begin
        tc_r      <= rdata[TEMP_W-1:0];
        pass_r    <= rdata[TEMP_W] | rdata[TEMP_W+1];
        acc_r     <= ACC_W'({16'd0, iw} * {16'd0, rdata[TEMP_W-1:0]});
        contrib_r <= CW'(iw);
      end else if (nb_on && !rdata[TEMP_W+1]) begin
        acc_r     <= acc_r + ACC_W'({16'd0, ow} * {17'd0, rdata[TEMP_W-1:0]});
        contrib_r <= contrib_r + CW'(ow);
      end
    end
  end

  // restoring divider, one quotient bit a cycle
  logic [ACC_W-1:0] num_r;
  logic [CW-1:0]    rem_r;
  logic [CW:0]      trial;
  logic             qbit;

  assign trial = {rem_r, num_r[ACC_W-1]};
  assign qbit  = trial >= {1'b0, contrib_r};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      num_r <= acc_r + ACC_W'(contrib_r >> 1);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[ACC_W-2:0], qbit};
      rem_r <= qbit ? CW'(trial - {1'b0, contrib_r}) : trial[CW-1:0];
    end
  end

  // output register
  logic              out_valid_r;
  logic [TEMP_W-1:0] out_temp_r, result;
  logic              out_last_r;

  always_comb begin
    if (pass_r) begin
      result = tc_r;
    end else if (num_r > ONE) begin
      result = ONE[TEMP_W-1:0];
    end else begin
      result = num_r[TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_temp_r <= result;
      out_last_r <= is_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_new_temperature = out_temp_r;
  assign out_last_of_frame   = out_last_r;

  `CHK_SAME(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_r || out_ready)
  `CHK_NEXT(a_contrib_set, clk, rst_n, dv_r && (tap_q_r == TAP_C), contrib_r != '0)
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid_r && !out_ready, out_valid_r)

endmodule

// ===== rtl/heat_diffusion_stencil_step.sv =====
`timescale 1ns / 1ps
// five-point heat diffusion stencil, one time step per pass over the grid
// in channel: one beat per grid cell in raster order, in_action 1 marks a pad
//   beat; after the last cell send grid_width+1 pads to flush the tail
// out channel: one beat per grid cell, starting once grid_width+1 beats are in;
//   out_last_of_frame marks the final cell, after which all counters restart
// cfg channel: index 0 grid width, 1 grid height, 2 outer coefficient (Q2.13);
//   a geometry write drops the frame in progress; after any cfg write, input is
//   held off in the next cycle
// a beat that yields no result is taken while the sequencer stays idle; a beat
//   that yields a result goes through acceptance, five reads through the ring
//   store's single read port, a drain state, a set-up state, the bit-serial
//   divider and the load of the output register
// the ring store holds two rows plus two cells; each result comes out of an
//   output register, so a new input beat is taken while it waits
// if the receiver stalls, the next result waits in the divider until the
//   output register frees; input stays blocked meanwhile
// reset (synchronous, active low) restores 1024 x 1024 and coefficient 819,
//   clears the counters; the ring store is not cleared, as any tap read before
//   it is written within a frame lies outside the grid and is masked
module heat_diffusion_stencil_step #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [hds_pkg::TEMP_W-1:0]     in_temperature,
  input  logic                           in_is_fixed,
  input  logic                           in_is_insulator,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [hds_pkg::TEMP_W-1:0]     out_new_temperature,
  output logic                           out_last_of_frame,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hds_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hds_pkg::*;

  // command and status between the sequencer and the datapath
  hds_cmd_t cmd;
  hds_sts_t sts;

  hds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hds_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_action           (in_action),
    .in_temperature      (in_temperature),
    .in_is_fixed         (in_is_fixed),
    .in_is_insulator     (in_is_insulator),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_new_temperature (out_new_temperature),
    .out_last_of_frame   (out_last_of_frame),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

endmodule
